// File: rtl/sip_pkg.sv
package sip_pkg;

  localparam int CW = 16;           // coordinate width
  localparam int DW = CW + 1;       // coordinate difference
  localparam int XW = 2 * DW;       // product and cross product, signed
  localparam int UW = 2 * CW + 1;   // magnitude of a normalized cross product
  localparam int RW = UW + 2;       // divider partial remainder headroom

  typedef struct packed {
    logic signed [CW-1:0] a_start_x;
    logic signed [CW-1:0] a_start_y;
    logic signed [CW-1:0] a_end_x;
    logic signed [CW-1:0] a_end_y;
    logic signed [CW-1:0] b_start_x;
    logic signed [CW-1:0] b_start_y;
    logic signed [CW-1:0] b_end_x;
    logic signed [CW-1:0] b_end_y;
  } seg_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] cross_x;
    logic signed [CW-1:0] cross_y;
  } pt_t;

  typedef struct packed {
    logic                 valid;
    logic signed [CW-1:0] base_x;
    logic signed [CW-1:0] base_y;
    logic signed [DW-1:0] dax;
    logic signed [DW-1:0] day;
    logic signed [XW-1:0] den;
    logic signed [XW-1:0] s;
    logic signed [XW-1:0] t;
  } cross_t;

  typedef struct packed {
    logic                 valid;
    logic                 hit;
    logic signed [CW-1:0] base_x;
    logic signed [CW-1:0] base_y;
    logic                 neg_x;
    logic                 neg_y;
    logic [CW-1:0]        mag_x;
    logic [CW-1:0]        mag_y;
    logic [UW-1:0]        t;
    logic [UW-1:0]        den;
    logic [UW-1:0]        rem_x;
    logic [UW-1:0]        rem_y;
    logic [CW-1:0]        q_x;
    logic [CW-1:0]        q_y;
  } div_t;

  typedef struct packed {
    logic [UW-1:0] r;
    logic [CW-1:0] q;
  } step_t;

  // one digit of q = floor(mag * t / den): shift in one multiplier bit,
  // then take out den up to twice (remainder stays below 3 * den)
  function automatic step_t div_step(logic [UW-1:0] r, logic [CW-1:0] q, logic b,
                                     logic [UW-1:0] t, logic [UW-1:0] den);
    logic [RW-1:0] r2;
    logic [RW-1:0] d1;
    logic [RW-1:0] d2;
    step_t         res;
    r2 = ({2'b00, r} << 1) + (b ? {2'b00, t} : {RW{1'b0}});
    d1 = {2'b00, den};
    d2 = d1 << 1;
    if (r2 >= d2) begin
      res.r = UW'(r2 - d2);
      res.q = (q << 1) + CW'(2);
    end else if (r2 >= d1) begin
      res.r = UW'(r2 - d1);
      res.q = (q << 1) + CW'(1);
    end else begin
      res.r = UW'(r2);
      res.q = q << 1;
    end
    return res;
  endfunction

endpackage

// File: rtl/segment_intersection_point.sv
// Integer segment intersection, fully pipelined: one request per cycle while
// no result waits with pt_stall high, one result per request in order. The
// pipeline runs through the cross stages, the sign fold, the divider chain
// that forms t * dir / denom, retiring one quotient bit per stage, one stage
// per coordinate bit, and the output register. The whole pipeline advances
// together and holds while a result waits with pt_stall high, so seg_stall
// simply follows that hold. Parallel or collinear segments (denom of zero)
// give no hit; with no hit the point is zero. Endpoints count as a hit.
module segment_intersection_point (
  input  logic          clk,
  input  logic          rst,
  input  logic          seg_valid,
  output logic          seg_stall,
  input  sip_pkg::seg_t seg,
  output logic          pt_valid,
  input  logic          pt_stall,
  output sip_pkg::pt_t  pt
);

  localparam int CW = sip_pkg::CW;

  logic en;
  sip_pkg::cross_t xs;
  sip_pkg::div_t   stg [0:CW];
  logic [CW-1:0]   sum_x, sum_y;

  // advance unless the output register holds an untaken result
  assign en        = !(pt_valid && pt_stall);
  assign seg_stall = !en;

  // differences, products, cross products
  sip_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .seg_valid (seg_valid),
    .seg       (seg),
    .xo        (xs)
  );

  // sign fold and range test
  sip_norm u_norm (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .xi  (xs),
    .dq  (stg[0])
  );

  // one quotient bit per stage, msb of the direction magnitude first
  for (genvar k = 0; k < CW; k++) begin : g_div
    sip_div_step #(.IDX(CW - 1 - k)) u_step (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .di  (stg[k]),
      .dq  (stg[k+1])
    );
  end

  // start point plus signed offset, wraps to coordinate width
  always_comb begin
    sum_x = stg[CW].base_x + (stg[CW].neg_x ? -stg[CW].q_x : stg[CW].q_x);
    sum_y = stg[CW].base_y + (stg[CW].neg_y ? -stg[CW].q_y : stg[CW].q_y);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid <= 1'b0;
    end else if (en) begin
      pt_valid <= stg[CW].valid;
    end
    if (en) begin
      pt.hit     <= stg[CW].hit;
      pt.cross_x <= stg[CW].hit ? sum_x : '0;
      pt.cross_y <= stg[CW].hit ? sum_y : '0;
    end
  end

endmodule

// File: rtl/sip_cross.sv
module sip_cross (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           seg_valid,
  input  sip_pkg::seg_t  seg,
  output sip_pkg::cross_t xo
);

  localparam int CW = sip_pkg::CW;
  localparam int DW = sip_pkg::DW;
  localparam int XW = sip_pkg::XW;

  // stage 1: differences
  logic                 v1;
  logic signed [CW-1:0] bx1, by1;
  logic signed [DW-1:0] dax, day, dbx, dby, d0x, d0y;
  // stage 2: products
  logic                 v2;
  logic signed [CW-1:0] bx2, by2;
  logic signed [DW-1:0] dax2, day2;
  logic signed [XW-1:0] pd1, pd2, ps1, ps2, pt1, pt2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      xo.valid <= 1'b0;
    end else if (en) begin
      v1       <= seg_valid;
      v2       <= v1;
      xo.valid <= v2;
    end
    if (en) begin
      bx1 <= seg.a_start_x;
      by1 <= seg.a_start_y;
      dax <= DW'(seg.a_end_x) - DW'(seg.a_start_x);
      day <= DW'(seg.a_end_y) - DW'(seg.a_start_y);
      dbx <= DW'(seg.b_end_x) - DW'(seg.b_start_x);
      dby <= DW'(seg.b_end_y) - DW'(seg.b_start_y);
      d0x <= DW'(seg.a_start_x) - DW'(seg.b_start_x);
      d0y <= DW'(seg.a_start_y) - DW'(seg.b_start_y);

      bx2  <= bx1;
      by2  <= by1;
      dax2 <= dax;
      day2 <= day;
      pd1  <= XW'(dax) * XW'(dby);
      pd2  <= XW'(day) * XW'(dbx);
      ps1  <= XW'(dax) * XW'(d0y);
      ps2  <= XW'(day) * XW'(d0x);
      pt1  <= XW'(dbx) * XW'(d0y);
      pt2  <= XW'(dby) * XW'(d0x);

      xo.base_x <= bx2;
      xo.base_y <= by2;
      xo.dax    <= dax2;
      xo.day    <= day2;
      xo.den    <= pd1 - pd2;
      xo.s      <= ps1 - ps2;
      xo.t      <= pt1 - pt2;
    end
  end

endmodule

// File: rtl/sip_norm.sv
module sip_norm (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  sip_pkg::cross_t xi,
  output sip_pkg::div_t   dq
);

  localparam int CW = sip_pkg::CW;
  localparam int DW = sip_pkg::DW;
  localparam int XW = sip_pkg::XW;
  localparam int UW = sip_pkg::UW;

  logic                 flip;
  logic signed [XW-1:0] den_n, s_n, t_n;
  logic signed [DW-1:0] ax_abs, ay_abs;
  logic                 hit;

  // make den positive so one closed range serves both signs
  always_comb begin
    flip   = xi.den[XW-1];
    den_n  = flip ? -xi.den : xi.den;
    s_n    = flip ? -xi.s : xi.s;
    t_n    = flip ? -xi.t : xi.t;
    ax_abs = xi.dax[DW-1] ? -xi.dax : xi.dax;
    ay_abs = xi.day[DW-1] ? -xi.day : xi.day;
    hit    = (den_n != '0) && !s_n[XW-1] && !t_n[XW-1] && (s_n <= den_n) && (t_n <= den_n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dq.valid <= 1'b0;
    end else if (en) begin
      dq.valid <= xi.valid;
    end
    if (en) begin
      dq.hit    <= hit;
      dq.base_x <= xi.base_x;
      dq.base_y <= xi.base_y;
      dq.neg_x  <= xi.dax[DW-1];
      dq.neg_y  <= xi.day[DW-1];
      dq.mag_x  <= ax_abs[CW-1:0];
      dq.mag_y  <= ay_abs[CW-1:0];
      dq.t      <= t_n[UW-1:0];
      dq.den    <= den_n[UW-1:0];
      dq.rem_x  <= '0;
      dq.rem_y  <= '0;
      dq.q_x    <= '0;
      dq.q_y    <= '0;
    end
  end

endmodule

// File: rtl/sip_div_step.sv
module sip_div_step #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  sip_pkg::div_t di,
  output sip_pkg::div_t dq
);

  sip_pkg::step_t sx, sy;

  always_comb begin
    sx = sip_pkg::div_step(di.rem_x, di.q_x, di.mag_x[IDX], di.t, di.den);
    sy = sip_pkg::div_step(di.rem_y, di.q_y, di.mag_y[IDX], di.t, di.den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dq.valid <= 1'b0;
    end else if (en) begin
      dq.valid <= di.valid;
    end
    if (en) begin
      dq.hit    <= di.hit;
      dq.base_x <= di.base_x;
      dq.base_y <= di.base_y;
      dq.neg_x  <= di.neg_x;
      dq.neg_y  <= di.neg_y;
      dq.mag_x  <= di.mag_x;
      dq.mag_y  <= di.mag_y;
      dq.t      <= di.t;
      dq.den    <= di.den;
      dq.rem_x  <= sx.r;
      dq.rem_y  <= sy.r;
      dq.q_x    <= sx.q;
      dq.q_y    <= sy.q;
    end
  end

endmodule

// File: rtl/sip_checker.sv
module sip_checker (
  input logic          clk,
  input logic          rst,
  input logic          seg_valid,
  input logic          seg_stall,
  input sip_pkg::seg_t seg,
  input logic          pt_valid,
  input logic          pt_stall,
  input sip_pkg::pt_t  pt
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    pt_valid && pt_stall |=> pt_valid && $stable(pt))
    else $error("result changed under stall");

  // no hit means a zero point
  a_zero: assert property (@(posedge clk) disable iff (rst)
    pt_valid && !pt.hit |-> pt.cross_x == '0 && pt.cross_y == '0)
    else $error("point not zero without hit");

  // requests are held back only by a waiting result
  a_stall: assert property (@(posedge clk) disable iff (rst)
    seg_stall |-> pt_valid && pt_stall)
    else $error("request stalled with free output");

  // a stalled request holds
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    seg_valid && seg_stall |=> seg_valid && $stable(seg))
    else $error("request changed under stall");

endmodule

bind segment_intersection_point sip_checker u_sip_checker (
  .clk       (clk),
  .rst       (rst),
  .seg_valid (seg_valid),
  .seg_stall (seg_stall),
  .seg       (seg),
  .pt_valid  (pt_valid),
  .pt_stall  (pt_stall),
  .pt        (pt)
);
